// ----- rtl/btba_pkg.sv -----
// Shared constants, types and helpers for the buddy tree bitmap allocator.
package btba_pkg;

    localparam int MaxDepth = 10;
    localparam int IdxW     = MaxDepth;
    // Sibling pairs share one memory word: word k holds nodes 2k+1 (bit 0) and 2k+2 (bit 1).
    localparam int WordAw   = MaxDepth - 1;
    localparam int DepthW   = 4;
    localparam int FuncW    = 2;
    localparam int TypeW    = 2;

    typedef enum logic [FuncW-1:0] {
        FUNC_SET  = 2'd0,
        FUNC_GET  = 2'd1,
        FUNC_FIND = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [TypeW-1:0] {
        TYPE_FREE      = 2'd0,
        TYPE_DATA      = 2'd1,
        TYPE_CONTAINER = 2'd2
    } t_ntype;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_KIDS,
        ST_EVAL,
        ST_WR_KIDS,
        ST_WR_SELF,
        ST_BACK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              is_root;
        logic              in_range;
        logic              is_base;
        logic              is_left;
        logic [WordAw-1:0] word_addr;
        logic              bit_sel;
        logic [IdxW-1:0]   left;
        logic [IdxW-1:0]   sibling;
        logic [IdxW-1:0]   parent;
    } t_step;

    function automatic logic [DepthW-1:0] live_depth(input logic [DepthW-1:0] d);
        logic [DepthW-1:0] r;
        r = d;
        if (d == '0) r = DepthW'(1);
        else if (d > DepthW'(MaxDepth)) r = DepthW'(MaxDepth);
        return r;
    endfunction

endpackage

// ----- rtl/btba_step.sv -----
// Index unit: heap navigation, memory word mapping and level checks for one node.
module btba_step (
    input  logic [btba_pkg::IdxW-1:0]   i_idx,
    input  logic [btba_pkg::DepthW-1:0] i_live_depth,
    output btba_pkg::t_step             o_step
);

    logic [btba_pkg::IdxW:0]   w_count;
    logic [btba_pkg::IdxW:0]   w_base;
    logic [btba_pkg::IdxW-1:0] w_idx_m1;

    always_comb begin
        w_count  = ((btba_pkg::IdxW+1)'(1) << i_live_depth) - (btba_pkg::IdxW+1)'(1);
        w_base   = ((btba_pkg::IdxW+1)'(1) << (i_live_depth - btba_pkg::DepthW'(1)))
                   - (btba_pkg::IdxW+1)'(1);
        w_idx_m1 = i_idx - btba_pkg::IdxW'(1);

        o_step.is_root   = (i_idx == '0);
        o_step.in_range  = ({1'b0, i_idx} < w_count);
        o_step.is_base   = ({1'b0, i_idx} >= w_base);
        o_step.is_left   = i_idx[0];
        o_step.word_addr = w_idx_m1[btba_pkg::IdxW-1:1];
        o_step.bit_sel   = w_idx_m1[0];
        o_step.left      = {i_idx[btba_pkg::IdxW-2:0], 1'b1};
        o_step.sibling   = i_idx + btba_pkg::IdxW'(1);
        // for an even non-root node, (idx-2)/2 == (idx-1)>>1
        o_step.parent    = {1'b0, w_idx_m1[btba_pkg::IdxW-1:1]};
    end

endmodule

// ----- rtl/buddy_tree_bitmap_allocator.sv -----
// Buddy tree bitmap allocator top level: sequencer, node bit memory and result register.
//
//  channel   ports            word layout (low bit up)
//  request   s_axis_*         tdata: node_index[9:0] node_type[11:10] target_depth[15:12]
//                             tuser: func[1:0]
//  result    m_axis_*         tdata: result_index[9:0] result_type[11:10] zero[15:12]
//                             tuser: found
//  config    i_cfg_*          tree_depth[3:0], written when i_cfg_we is high
//
//  Set and get step through fetch, kids, eval, any writes a set needs and done; result
//  valid and s_axis_tready rise together as the block returns to idle.
//  Find free spends fetch, kids and eval on each node visited, a back step on each climb
//  or move to a sibling, and done to post the result, all on one memory port.
//  After reset 512 word writes clear the node memory; s_axis_tready stays low meanwhile.
//  Only one request is in flight; a result waiting on m_axis_tready holds the next result
//  at its last step but does not block accepting the next request.
module buddy_tree_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // node_index[9:0], node_type[11:10], target_depth[15:12]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result_index[9:0], result_type[11:10], zero[15:12]
    output logic        m_axis_tuser    // found
);

    localparam int IdxW   = btba_pkg::IdxW;
    localparam int WordAw = btba_pkg::WordAw;
    localparam int DepthW = btba_pkg::DepthW;

    btba_pkg::t_state r_state, n_state;
    btba_pkg::t_func  r_func, n_func;
    btba_pkg::t_ntype r_ntype, n_ntype;
    btba_pkg::t_step  w_step;

    logic [DepthW-1:0] r_tree_depth;
    logic [DepthW-1:0] w_live;
    logic [IdxW-1:0]   r_idx, n_idx;
    logic [DepthW-1:0] r_depth, n_depth;
    logic [DepthW-1:0] r_limit, n_limit;
    logic [1:0]        r_self_word, n_self_word;
    logic              r_self_bit, n_self_bit;
    logic              r_wbit, n_wbit;
    logic              r_root, n_root;
    logic [WordAw:0]   r_clr_cnt, n_clr_cnt;

    logic              r_pend_found, n_pend_found;
    logic [IdxW-1:0]   r_pend_idx, n_pend_idx;
    logic [1:0]        r_pend_type, n_pend_type;

    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic [IdxW-1:0]   r_out_idx, n_out_idx;
    logic [1:0]        r_out_type, n_out_type;

    logic [1:0]        r_mem [2**WordAw];
    logic [1:0]        r_rdata;
    logic [WordAw-1:0] w_raddr, w_waddr;
    logic [1:0]        w_wdata;
    logic              w_we;
    btba_pkg::t_ntype  w_type;

    assign w_live = btba_pkg::live_depth(r_tree_depth);

    btba_step u_step (
        .i_idx        (r_idx),
        .i_live_depth (w_live),
        .o_step       (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // type of the current node; r_self_bit and r_rdata (child pair) are valid in ST_EVAL
    always_comb begin
        if (!w_step.in_range || !r_self_bit) begin
            w_type = btba_pkg::TYPE_FREE;
        end else if (w_step.is_base) begin
            w_type = btba_pkg::TYPE_DATA;
        end else if (r_rdata != 2'b00) begin
            w_type = btba_pkg::TYPE_CONTAINER;
        end else begin
            w_type = btba_pkg::TYPE_DATA;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_ntype      = r_ntype;
        n_idx        = r_idx;
        n_depth      = r_depth;
        n_limit      = r_limit;
        n_self_word  = r_self_word;
        n_self_bit   = r_self_bit;
        n_wbit       = r_wbit;
        n_root       = r_root;
        n_clr_cnt    = r_clr_cnt;
        n_pend_found = r_pend_found;
        n_pend_idx   = r_pend_idx;
        n_pend_type  = r_pend_type;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_found  = r_out_found;
        n_out_idx    = r_out_idx;
        n_out_type   = r_out_type;
        w_raddr      = w_step.word_addr;
        w_waddr      = w_step.word_addr;
        w_wdata      = 2'b00;
        w_we         = 1'b0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            btba_pkg::ST_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_cnt[WordAw-1:0];
                n_clr_cnt = r_clr_cnt + (WordAw+1)'(1);
                if (r_clr_cnt[WordAw]) begin
                    w_we    = 1'b0;
                    n_state = btba_pkg::ST_IDLE;
                end
            end
            btba_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_func  = btba_pkg::t_func'(s_axis_tuser);
                    n_ntype = btba_pkg::t_ntype'(s_axis_tdata[11:10]);
                    n_limit = s_axis_tdata[15:12];
                    n_depth = '0;
                    n_idx   = s_axis_tdata[9:0];
                    n_state = btba_pkg::ST_FETCH;
                    if (btba_pkg::t_func'(s_axis_tuser) == btba_pkg::FUNC_FIND) begin
                        n_idx = '0;
                    end else if (btba_pkg::t_func'(s_axis_tuser) == btba_pkg::FUNC_NONE) begin
                        n_pend_found = 1'b0;
                        n_pend_idx   = '0;
                        n_pend_type  = btba_pkg::TYPE_FREE;
                        n_state      = btba_pkg::ST_DONE;
                    end
                end
            end
            btba_pkg::ST_FETCH: begin
                n_state = btba_pkg::ST_KIDS;
            end
            btba_pkg::ST_KIDS: begin
                n_self_word = r_rdata;
                n_self_bit  = w_step.is_root ? r_root : r_rdata[w_step.bit_sel];
                // child pair of node i lives in word i; only used for in-range non-base nodes
                w_raddr     = r_idx[WordAw-1:0];
                n_state     = btba_pkg::ST_EVAL;
            end
            btba_pkg::ST_EVAL: begin
                n_pend_found = 1'b1;
                n_pend_idx   = r_idx;
                n_pend_type  = btba_pkg::TYPE_FREE;
                n_state      = btba_pkg::ST_DONE;
                unique case (r_func)
                    btba_pkg::FUNC_SET: begin
                        if (w_step.in_range) begin
                            unique case (r_ntype)
                                btba_pkg::TYPE_FREE: begin
                                    n_wbit  = 1'b0;
                                    n_state = btba_pkg::ST_WR_SELF;
                                end
                                btba_pkg::TYPE_DATA: begin
                                    n_wbit  = 1'b1;
                                    n_state = w_step.is_base ? btba_pkg::ST_WR_SELF
                                                             : btba_pkg::ST_WR_KIDS;
                                end
                                btba_pkg::TYPE_CONTAINER: begin
                                    n_wbit  = 1'b1;
                                    n_state = btba_pkg::ST_WR_SELF;
                                end
                                default: begin
                                    n_state = btba_pkg::ST_DONE;
                                end
                            endcase
                        end
                    end
                    btba_pkg::FUNC_GET: begin
                        n_pend_type = w_type;
                    end
                    btba_pkg::FUNC_FIND: begin
                        if (w_type == btba_pkg::TYPE_FREE) begin
                            n_state = btba_pkg::ST_DONE;
                        end else if (w_type == btba_pkg::TYPE_DATA || r_depth == r_limit) begin
                            n_state = btba_pkg::ST_BACK;
                        end else begin
                            n_idx   = w_step.left;
                            n_depth = r_depth + DepthW'(1);
                            n_state = btba_pkg::ST_FETCH;
                        end
                    end
                    default: begin
                        n_state = btba_pkg::ST_DONE;
                    end
                endcase
            end
            btba_pkg::ST_WR_KIDS: begin
                w_we    = 1'b1;
                w_waddr = r_idx[WordAw-1:0];
                w_wdata = 2'b00;
                n_state = btba_pkg::ST_WR_SELF;
            end
            btba_pkg::ST_WR_SELF: begin
                if (w_step.is_root) begin
                    n_root = r_wbit;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_step.bit_sel ? {r_wbit, r_self_word[0]}
                                             : {r_self_word[1], r_wbit};
                end
                n_state = btba_pkg::ST_DONE;
            end
            btba_pkg::ST_BACK: begin
                // climb out of finished right subtrees, then move to the right sibling
                if (w_step.is_root) begin
                    n_pend_found = 1'b0;
                    n_pend_idx   = '0;
                    n_pend_type  = btba_pkg::TYPE_FREE;
                    n_state      = btba_pkg::ST_DONE;
                end else if (w_step.is_left) begin
                    n_idx   = w_step.sibling;
                    n_state = btba_pkg::ST_FETCH;
                end else begin
                    n_idx   = w_step.parent;
                    n_depth = r_depth - DepthW'(1);
                end
            end
            btba_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_pend_found;
                    n_out_idx   = r_pend_idx;
                    n_out_type  = r_pend_type;
                    n_state     = btba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = btba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= btba_pkg::ST_CLEAR;
            r_clr_cnt    <= '0;
            r_root       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tree_depth <= DepthW'(btba_pkg::MaxDepth);
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tree_depth <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_ntype      <= n_ntype;
        r_idx        <= n_idx;
        r_depth      <= n_depth;
        r_limit      <= n_limit;
        r_self_word  <= n_self_word;
        r_self_bit   <= n_self_bit;
        r_wbit       <= n_wbit;
        r_pend_found <= n_pend_found;
        r_pend_idx   <= n_pend_idx;
        r_pend_type  <= n_pend_type;
        r_out_found  <= n_out_found;
        r_out_idx    <= n_out_idx;
        r_out_type   <= n_out_type;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {4'b0000, r_out_type, r_out_idx};

    a_no_result_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btba_pkg::ST_CLEAR) |-> !r_out_valid)
        else $error("result valid during memory clear");

    a_accept_leaves_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != btba_pkg::ST_IDLE))
        else $error("accepted word did not start a request");

    a_root_depth_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btba_pkg::ST_FETCH && r_idx == '0) |-> (r_depth == '0))
        else $error("depth tracking out of step with node index");

    a_back_from_root_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btba_pkg::ST_BACK && r_idx == '0) |=> (r_state == btba_pkg::ST_DONE))
        else $error("search did not end after backtracking to the root");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the buddy tree bitmap allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // ~1700 words; even if each were a full-tree search, all would fit in the cycle limit
    localparam int CycleLimit   = 30_000_000;
    localparam int SettleCycles = 16;
    localparam int PhaseWords   = 100;

    typedef struct {
        btba_pkg::t_func func;
        logic [9:0]  idx;
        logic [1:0]  ntype;
        logic [3:0]  tdep;
    } t_req;

    typedef struct {
        logic        found;
        logic [9:0]  idx;
        logic [1:0]  rtype;
    } t_res;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [3:0]  cfg_val;
        t_req        rq;
        bit          typed;
        t_res        want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // node_index[9:0], node_type[11:10], target_depth[15:12]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // result_index[9:0], result_type[11:10], zero[15:12]
    logic        m_axis_tuser;   // found

    buddy_tree_bitmap_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow of the node bitmap and the depth register
    bit         node_map [0:1023];
    logic [3:0] depth_reg;

    t_res pending_results[$];
    int   alloc_nodes[$];
    int   errors;
    int   results_seen;
    int   items_sent;
    int   cycles;
    int   send_gap_max;
    int   recv_stall_max;
    int   hold_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int eff_depth();
        if (depth_reg == 4'd0) return 1;
        if (depth_reg > 4'(btba_pkg::MaxDepth)) return btba_pkg::MaxDepth;
        return int'(depth_reg);
    endfunction

    function automatic int span();
        return (1 << eff_depth()) - 1;
    endfunction

    function automatic int level_of(input int idx);
        int v;
        int d;
        v = idx + 1;
        d = 0;
        while (v > 1) begin
            v = v >> 1;
            d++;
        end
        return d;
    endfunction

    function automatic bit bit_at(input int idx);
        if (idx >= span()) return 1'b0;
        return node_map[idx];
    endfunction

    function automatic void put_bit(input int idx, input bit v);
        if (idx < span()) node_map[idx] = v;
    endfunction

    function automatic logic [1:0] kind_of(input int idx);
        if (!bit_at(idx)) return btba_pkg::TYPE_FREE;
        if (level_of(idx) == eff_depth() - 1) return btba_pkg::TYPE_DATA;
        if (bit_at(2 * idx + 1) || bit_at(2 * idx + 2)) return btba_pkg::TYPE_CONTAINER;
        return btba_pkg::TYPE_DATA;
    endfunction

    // left-first preorder walk with an explicit stack
    function automatic bit find_free(input int limit, output int hit);
        int stk [0:63];
        int sp;
        int n;
        logic [1:0] k;
        sp = 1;
        stk[0] = 0;
        hit = 0;
        while (sp > 0) begin
            sp--;
            n = stk[sp];
            if (n >= span()) continue;
            k = kind_of(n);
            if (k == btba_pkg::TYPE_FREE) begin
                hit = n;
                return 1'b1;
            end
            if (k == btba_pkg::TYPE_DATA) continue;
            if (level_of(n) == limit) continue;
            stk[sp] = 2 * n + 2;
            stk[sp + 1] = 2 * n + 1;
            sp += 2;
        end
        return 1'b0;
    endfunction

    function automatic t_res apply_request(input t_req rq);
        t_res r;
        int   n;
        int   hit;
        r = '{found: 1'b0, idx: '0, rtype: '0};
        n = int'(rq.idx);
        case (rq.func)
            btba_pkg::FUNC_SET: begin
                if (n < span()) begin
                    if (rq.ntype == btba_pkg::TYPE_FREE) begin
                        put_bit(n, 1'b0);
                    end else if (rq.ntype == btba_pkg::TYPE_DATA) begin
                        if (level_of(n) != eff_depth() - 1) begin
                            put_bit(2 * n + 1, 1'b0);
                            put_bit(2 * n + 2, 1'b0);
                        end
                        put_bit(n, 1'b1);
                    end else if (rq.ntype == btba_pkg::TYPE_CONTAINER) begin
                        put_bit(n, 1'b1);
                    end
                end
                r.found = 1'b1;
                r.idx = rq.idx;
            end
            btba_pkg::FUNC_GET: begin
                r.found = 1'b1;
                r.idx = rq.idx;
                r.rtype = kind_of(n);
            end
            btba_pkg::FUNC_FIND: begin
                if (find_free(int'(rq.tdep), hit)) begin
                    r.found = 1'b1;
                    r.idx = 10'(hit);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_req mk_req(input btba_pkg::t_func f, input int idx, input int nt,
                                    input int td);
        t_req rq;
        rq.func = f;
        rq.idx = 10'(idx);
        rq.ntype = 2'(nt);
        rq.tdep = 4'(td);
        return rq;
    endfunction

    function automatic t_row req_row(input btba_pkg::t_func f, input int idx, input int nt,
                                     input int td);
        t_row r;
        r.kind = ROW_REQ;
        r.cfg_val = '0;
        r.rq = mk_req(f, idx, nt, td);
        r.typed = 1'b0;
        r.want = '{found: 1'b0, idx: '0, rtype: '0};
        return r;
    endfunction

    function automatic t_row chk_row(input btba_pkg::t_func f, input int idx, input int nt,
                                     input int td, input bit fnd, input int ridx,
                                     input int rt);
        t_row r;
        r = req_row(f, idx, nt, td);
        r.typed = 1'b1;
        r.want = '{found: fnd, idx: 10'(ridx), rtype: 2'(rt)};
        return r;
    endfunction

    function automatic t_row cfg_row(input int v);
        t_row r;
        r = req_row(btba_pkg::FUNC_NONE, 0, 0, 0);
        r.kind = ROW_CFG;
        r.cfg_val = 4'(v);
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] result %0d: %s got %0d expected %0d", $realtime, results_seen, what,
                 got, want);
        errors++;
    endtask

    // drive one request word, predict at the accepting edge
    task automatic issue(input t_req rq, input bit typed, input t_res want, output t_res got);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {rq.tdep, rq.ntype, rq.idx};
        s_axis_tuser = rq.func;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        got = apply_request(rq);
        pending_results.push_back(typed ? want : got);
        items_sent++;
    endtask

    task automatic ask(input btba_pkg::t_func f, input int idx, input int nt, input int td,
                       output t_res got);
        t_res none;
        none = '{found: 1'b0, idx: '0, rtype: '0};
        issue(mk_req(f, idx, nt, td), 1'b0, none, got);
    endtask

    // stop sending and wait until every result is back and the block has settled
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_depth(input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        depth_reg = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // find a slot, split down to the requested level, then mark it data
    task automatic alloc_op();
        t_res r;
        int   lim;
        int   cur;
        lim = $urandom_range(0, (eff_depth() > 8) ? 7 : eff_depth() - 1);
        ask(btba_pkg::FUNC_FIND, $urandom_range(0, 1023), $urandom_range(0, 3), lim, r);
        if (!r.found) return;
        cur = int'(r.idx);
        while (level_of(cur) < lim) begin
            ask(btba_pkg::FUNC_SET, cur, btba_pkg::TYPE_CONTAINER, $urandom_range(0, 15), r);
            cur = 2 * cur + 1 + $urandom_range(0, 1);
        end
        ask(btba_pkg::FUNC_SET, cur, btba_pkg::TYPE_DATA, $urandom_range(0, 15), r);
        alloc_nodes.push_back(cur);
        if ($urandom_range(0, 1) == 0)
            ask(btba_pkg::FUNC_GET,
                (cur > 0 && $urandom_range(0, 1) == 0) ? (cur - 1) / 2 : cur,
                $urandom_range(0, 3), $urandom_range(0, 15), r);
    endtask

    task automatic free_op();
        t_res r;
        int   k;
        int   n;
        if (alloc_nodes.size() == 0) return;
        k = $urandom_range(0, alloc_nodes.size() - 1);
        n = alloc_nodes[k];
        alloc_nodes.delete(k);
        ask(btba_pkg::FUNC_SET, n, btba_pkg::TYPE_FREE, $urandom_range(0, 15), r);
        if (n > 0 && $urandom_range(0, 3) == 0)
            ask(btba_pkg::FUNC_SET, (n - 1) / 2, btba_pkg::TYPE_FREE,
                $urandom_range(0, 15), r);
    endtask

    task automatic noise_op();
        t_res r;
        int   idx;
        idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, span() - 1)
                                          : $urandom_range(0, 1023);
        ask(btba_pkg::t_func'($urandom_range(0, 3)), idx, $urandom_range(0, 3),
            $urandom_range(0, 15), r);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected word, found", int'(m_axis_tuser), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.found)
                    report("found", int'(m_axis_tuser), int'(want.found));
                if (m_axis_tdata[9:0] !== want.idx)
                    report("result_index", int'(m_axis_tdata[9:0]), int'(want.idx));
                if (m_axis_tdata[11:10] !== want.rtype)
                    report("result_type", int'(m_axis_tdata[11:10]), int'(want.rtype));
                if (m_axis_tdata[15:12] !== 4'd0)
                    report("pad bits", int'(m_axis_tdata[15:12]), 0);
            end
            results_seen++;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, recv_stall_max);
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        t_row       dir_rows[$];
        t_res       r;
        int         depth_plan[$];
        int         phase_end;
        int         pick;
        int         p;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        cycles = 0;
        send_gap_max = 4;
        recv_stall_max = 4;
        hold_cycles = 0;
        depth_reg = 4'd10;
        foreach (node_map[i]) node_map[i] = 1'b0;

        // after reset: empty tree of ten levels
        dir_rows.push_back(chk_row(btba_pkg::FUNC_GET, 0, 0, 0, 1'b1, 0, btba_pkg::TYPE_FREE));
        dir_rows.push_back(chk_row(btba_pkg::FUNC_FIND, 0, 0, 9, 1'b1, 0, btba_pkg::TYPE_FREE));
        dir_rows.push_back(chk_row(btba_pkg::FUNC_GET, 1022, 3, 15, 1'b1, 1022,
                                   btba_pkg::TYPE_FREE));
        // node past the end of the tree
        dir_rows.push_back(chk_row(btba_pkg::FUNC_GET, 1023, 0, 0, 1'b1, 1023,
                                   btba_pkg::TYPE_FREE));
        dir_rows.push_back(chk_row(btba_pkg::FUNC_SET, 1023, btba_pkg::TYPE_DATA, 0, 1'b1, 1023,
                                   btba_pkg::TYPE_FREE));
        dir_rows.push_back(chk_row(btba_pkg::FUNC_NONE, 5, 1, 3, 1'b0, 0, btba_pkg::TYPE_FREE));
        // a container with no children reads as data
        dir_rows.push_back(chk_row(btba_pkg::FUNC_SET, 0, btba_pkg::TYPE_CONTAINER, 0, 1'b1, 0,
                                   btba_pkg::TYPE_FREE));
        dir_rows.push_back(chk_row(btba_pkg::FUNC_GET, 0, 0, 0, 1'b1, 0, btba_pkg::TYPE_DATA));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 1, btba_pkg::TYPE_DATA, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_GET, 0, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_FIND, 0, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_FIND, 0, 0, 15));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 1, 3, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_GET, 1, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 1022, btba_pkg::TYPE_DATA, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_GET, 1022, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 0, btba_pkg::TYPE_DATA, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_FIND, 0, 0, 9));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 0, btba_pkg::TYPE_FREE, 0));
        // depth 0 behaves as a single-node tree
        dir_rows.push_back(cfg_row(0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 0, btba_pkg::TYPE_DATA, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_GET, 1, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_FIND, 0, 0, 9));
        // depth above the maximum clamps; hidden bits reappear
        dir_rows.push_back(cfg_row(15));
        dir_rows.push_back(req_row(btba_pkg::FUNC_GET, 0, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_GET, 1022, 0, 0));
        dir_rows.push_back(req_row(btba_pkg::FUNC_SET, 0, btba_pkg::TYPE_FREE, 0));
        dir_rows.push_back(cfg_row(10));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                write_depth(dir_rows[i].cfg_val);
            end else begin
                issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want, r);
            end
        end

        depth_plan = '{3, 1, 10, 0, 15, 2, 4, 5, 6, 7, 8, 9, 11, 12, 13, 14};
        p = 0;
        foreach (depth_plan[ph]) begin
            drain();
            write_depth(4'(depth_plan[ph]));
            alloc_nodes.delete();
            case (ph % 4)
                0: begin send_gap_max = 0; recv_stall_max = 0; end
                1: begin send_gap_max = 4; recv_stall_max = 4; end
                2: begin send_gap_max = 0; recv_stall_max = 4; end
                default: begin send_gap_max = 4; recv_stall_max = 0; end
            endcase
            // block fills up and backs up the request side
            if (ph == 2) hold_cycles = 400;
            phase_end = items_sent + PhaseWords;
            while (items_sent < phase_end) begin
                // sender waits for every result mid-phase
                if (ph == 5 && p == 0 && items_sent >= phase_end - PhaseWords / 2) begin
                    drain();
                    p = 1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55) alloc_op();
                else if (pick < 75) free_op();
                else if (pick < 85) begin
                    if (alloc_nodes.size() > 0 && $urandom_range(0, 1) == 0)
                        ask(btba_pkg::FUNC_GET,
                            alloc_nodes[$urandom_range(0, alloc_nodes.size() - 1)],
                            $urandom_range(0, 3), $urandom_range(0, 15), r);
                    else
                        ask(btba_pkg::FUNC_GET, $urandom_range(0, span() - 1),
                            $urandom_range(0, 3), $urandom_range(0, 15), r);
                end
                else noise_op();
            end
        end

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/btba_pkg.sv
rtl/btba_step.sv
rtl/buddy_tree_bitmap_allocator.sv
tb/testbench.sv
